@@ src/fmva_pkg.sv @@
`timescale 1ns / 1ps

package fmva_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [6:0]  note_key;
		logic [12:0] freq_word;
	} cmd_t;

	typedef struct packed {
		logic [7:0] reg_addr;
		logic [7:0] reg_data;
		logic       last_write;
	} result_t;

	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;

	localparam logic [7:0] ADDR_FREQ_LO = 8'hA0;
	localparam logic [7:0] ADDR_FREQ_HI = 8'hB0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ON_INIT,
		S_ON_TEST,
		S_ON_ADV,
		S_ON_LO,
		S_ON_HI,
		S_OFF_INIT,
		S_OFF_TEST,
		S_OFF_ADV,
		S_OFF_LO,
		S_OFF_HI
	} step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_DISPATCH,
		COND_FREE,
		COND_MATCH,
		COND_ON_END,
		COND_OFF_END
	} cond_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_LO,
		EMIT_HI_ON,
		EMIT_HI_OFF
	} emit_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_FIRST,
		PTR_ZERO,
		PTR_INC
	} ptr_op_t;

	typedef struct packed {
		cond_t   cond;
		step_t   tgt_t;
		step_t   tgt_f;
		emit_t   emit;
		logic    alloc;
		logic    free_voice;
		ptr_op_t ptr;
	} uctl_t;

endpackage

@@ src/fmva_ucode_rom.sv @@
`timescale 1ns / 1ps

module fmva_ucode_rom (
	input  fmva_pkg::step_t step,
	output fmva_pkg::uctl_t ctl
);

	always_comb begin
		unique case (step)
			fmva_pkg::S_IDLE: begin
				ctl = '{fmva_pkg::COND_DISPATCH, fmva_pkg::S_IDLE, fmva_pkg::S_IDLE,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_ON_INIT: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_ON_TEST, fmva_pkg::S_ON_TEST,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_FIRST};
			end
			fmva_pkg::S_ON_TEST: begin
				ctl = '{fmva_pkg::COND_FREE, fmva_pkg::S_ON_LO, fmva_pkg::S_ON_ADV,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_ON_ADV: begin
				ctl = '{fmva_pkg::COND_ON_END, fmva_pkg::S_IDLE, fmva_pkg::S_ON_TEST,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_INC};
			end
			fmva_pkg::S_ON_LO: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_ON_HI, fmva_pkg::S_ON_HI,
					fmva_pkg::EMIT_LO, 1'b1, 1'b0, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_ON_HI: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_IDLE, fmva_pkg::S_IDLE,
					fmva_pkg::EMIT_HI_ON, 1'b0, 1'b0, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_OFF_INIT: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_OFF_TEST, fmva_pkg::S_OFF_TEST,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_ZERO};
			end
			fmva_pkg::S_OFF_TEST: begin
				ctl = '{fmva_pkg::COND_MATCH, fmva_pkg::S_OFF_LO, fmva_pkg::S_OFF_ADV,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_OFF_ADV: begin
				ctl = '{fmva_pkg::COND_OFF_END, fmva_pkg::S_IDLE, fmva_pkg::S_OFF_TEST,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_INC};
			end
			fmva_pkg::S_OFF_LO: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_OFF_HI, fmva_pkg::S_OFF_HI,
					fmva_pkg::EMIT_LO, 1'b0, 1'b1, fmva_pkg::PTR_HOLD};
			end
			fmva_pkg::S_OFF_HI: begin
				ctl = '{fmva_pkg::COND_OFF_END, fmva_pkg::S_IDLE, fmva_pkg::S_OFF_TEST,
					fmva_pkg::EMIT_HI_OFF, 1'b0, 1'b0, fmva_pkg::PTR_INC};
			end
			default: begin
				ctl = '{fmva_pkg::COND_ALWAYS, fmva_pkg::S_IDLE, fmva_pkg::S_IDLE,
					fmva_pkg::EMIT_NONE, 1'b0, 1'b0, fmva_pkg::PTR_HOLD};
			end
		endcase
	end

endmodule

@@ src/fm_voice_allocator.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                      | Handshake
// ----------+----------------------------+---------------------------------
// command   | start, busy, cmd           | taken when start & !busy
// config    | cfg_we, cfg_wdata          | mute written when cfg_we is high
// result    | strobe, result             | valid when strobe is high, no backpressure
//
// A microcoded sequencer walks the voices one at a time: a test step, then an advance
// step, or the LO and HI write steps for the chosen voice. Note-on: probes from the
// voice after the last allocated one, stops at the first free voice, or ends with no write.
// Note-off: walks every voice and writes both words for each matching voice.
// Other events and muted note-ons: busy never rises.
// Each word is registered and appears in the cycle after its step; the receiver cannot stall.
// Reset frees all voices, clears the last voice and the mute bit.

module fm_voice_allocator #(
	parameter int NUM_VOICES = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fmva_pkg::cmd_t    cmd,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output logic              strobe,
	output fmva_pkg::result_t result
);

	localparam int VW = $clog2(NUM_VOICES);
	localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VOICES - 1);

	fmva_pkg::step_t step_q, step_d;
	fmva_pkg::uctl_t ctl;

	logic                  mute_q;
	logic [6:0]            voice_key_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] voice_busy_q;
	logic [VW-1:0]         last_voice_q;
	logic [VW-1:0]         ptr_q;
	logic [VW-1:0]         cnt_q;
	logic [6:0]            key_q;
	logic [12:0]           freq_q;
	logic [NUM_VOICES-1:0] match_q;
	logic [NUM_VOICES-1:0] match_d;
	logic                  accept;
	logic                  cond_hit;
	logic                  strobe_q;
	fmva_pkg::result_t     result_q;

	fmva_ucode_rom u_rom (
		.step (step_q),
		.ctl  (ctl)
	);

	assign accept = start && (step_q == fmva_pkg::S_IDLE);
	assign busy   = (step_q != fmva_pkg::S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	always_comb begin
		for (int v = 0; v < NUM_VOICES; v++) begin
			match_d[v] = voice_busy_q[v] && (voice_key_q[v] == cmd.note_key);
		end
	end

	always_comb begin
		unique case (ctl.cond)
			fmva_pkg::COND_FREE:    cond_hit = !voice_busy_q[ptr_q];
			fmva_pkg::COND_MATCH:   cond_hit = match_q[ptr_q];
			fmva_pkg::COND_ON_END:  cond_hit = (cnt_q == LAST_IDX);
			fmva_pkg::COND_OFF_END: cond_hit = (ptr_q == LAST_IDX);
			default:                cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		step_d = cond_hit ? ctl.tgt_t : ctl.tgt_f;
		if (ctl.cond == fmva_pkg::COND_DISPATCH) begin
			step_d = fmva_pkg::S_IDLE;
			if (start) begin
				priority if (cmd.opcode == fmva_pkg::OP_NOTE_ON && !mute_q) begin
					step_d = fmva_pkg::S_ON_INIT;
				end else if (cmd.opcode == fmva_pkg::OP_NOTE_OFF) begin
					step_d = fmva_pkg::S_OFF_INIT;
				end else begin
					step_d = fmva_pkg::S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fmva_pkg::S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
		end else if (cfg_we) begin
			mute_q <= cfg_wdata;
		end
	end

	// latch the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= cmd.note_key;
			freq_q <= cmd.freq_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
		end else if (accept) begin
			match_q <= match_d;
		end else if (ctl.free_voice) begin
			match_q[ptr_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (ctl.ptr)
				fmva_pkg::PTR_FIRST: begin
					ptr_q <= (last_voice_q == LAST_IDX) ? '0 : last_voice_q + VW'(1);
					cnt_q <= VW'(1);
				end
				fmva_pkg::PTR_ZERO: begin
					ptr_q <= '0;
				end
				fmva_pkg::PTR_INC: begin
					ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + VW'(1);
					cnt_q <= cnt_q + VW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_busy_q <= '0;
			last_voice_q <= '0;
		end else if (ctl.alloc) begin
			voice_busy_q[ptr_q] <= 1'b1;
			last_voice_q        <= ptr_q;
		end else if (ctl.free_voice) begin
			voice_busy_q[ptr_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			voice_key_q[ptr_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (ctl.emit != fmva_pkg::EMIT_NONE);
		end
	end

	// the off word is last once no matching voice is left
	always_ff @(posedge clk) begin
		unique case (ctl.emit)
			fmva_pkg::EMIT_LO: begin
				result_q.reg_addr   <= fmva_pkg::ADDR_FREQ_LO + 8'(ptr_q);
				result_q.reg_data   <= freq_q[7:0];
				result_q.last_write <= 1'b0;
			end
			fmva_pkg::EMIT_HI_ON: begin
				result_q.reg_addr   <= fmva_pkg::ADDR_FREQ_HI + 8'(ptr_q);
				result_q.reg_data   <= {2'b00, 1'b1, freq_q[12:8]};
				result_q.last_write <= 1'b1;
			end
			fmva_pkg::EMIT_HI_OFF: begin
				result_q.reg_addr   <= fmva_pkg::ADDR_FREQ_HI + 8'(ptr_q);
				result_q.reg_data   <= {3'b000, freq_q[12:8]};
				result_q.last_write <= (match_q == '0);
			end
			default: begin
			end
		endcase
	end

	a_strobe_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word without a sequencer step");

	a_on_hi_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == fmva_pkg::S_ON_HI) |=> !busy)
		else $error("note-on did not end after its key-on word");

	a_match_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == fmva_pkg::S_OFF_TEST && match_q[ptr_q]) |-> voice_busy_q[ptr_q])
		else $error("note-off matched a free voice");

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_voice_q <= LAST_IDX)
		else $error("last voice out of range");

	a_alloc_free_voice: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> !voice_busy_q[ptr_q])
		else $error("allocating a busy voice");

endmodule
